// ----- rtl/icc_pkg.sv -----
package icc_pkg;

    // Field widths fixed by the bus and source numbering
    localparam int unsigned CMD_W  = 2;
    localparam int unsigned OFF_W  = 22;
    localparam int unsigned DATA_W = 32;
    localparam int unsigned SRC_W  = 5;
    localparam int unsigned PRIO_W = 3;
    localparam int unsigned CTX_N  = 2;

    // Transaction commands
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LEVEL = 2'd2;

    // Register map offsets
    localparam logic [OFF_W-1:0] OFF_PEND_BASE = 22'h001000;
    localparam logic [OFF_W-1:0] OFF_ENA_BASE  = 22'h002000;
    localparam logic [OFF_W-1:0] OFF_ENA_END   = 22'h002100;
    localparam logic [OFF_W-1:0] OFF_THR0      = 22'h200000;
    localparam logic [OFF_W-1:0] OFF_CLAIM0    = 22'h200004;
    localparam logic [OFF_W-1:0] OFF_THR1      = 22'h201000;
    localparam logic [OFF_W-1:0] OFF_CLAIM1    = 22'h201004;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [OFF_W-1:0]  reg_offset;
        logic [DATA_W-1:0] write_data;
        logic [SRC_W-1:0]  source_number;
        logic              source_level;
    } t_in;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic [CTX_N-1:0]  context_lines;
    } t_out;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_ARM,
        S_CLAIM_SCAN,
        S_CLAIM_CLEAR,
        S_LINE_SCAN,
        S_DONE
    } t_state;

    // Register file controls
    typedef struct packed {
        logic wr;        // register write
        logic lvl;       // source level change
        logic clr;       // clear claimed pending bit
        logic scan_sel;  // priority read port follows the scan index
    } t_reg_ctl;

    // Scan unit controls
    typedef struct packed {
        logic start;
        logic step;
    } t_scan_ctl;

endpackage

// ----- rtl/icc_regs.sv -----
module icc_regs
    import icc_pkg::*;
#(
    parameter int unsigned NUM_SOURCES = 32,
    parameter int unsigned SW          = 5
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_reg_ctl          i_ctl,
    input  logic [OFF_W-1:0]  i_off,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [SRC_W-1:0]  i_src,
    input  logic              i_lvl,
    input  logic [SW-1:0]     i_clr_id,
    input  logic [SW-1:0]     i_scan_idx,
    output logic [DATA_W-1:0] o_rdata,
    output logic [PRIO_W-1:0] o_prio,
    output logic [CTX_N-1:0]  o_cand,
    output logic [DATA_W-1:0] o_thr0,
    output logic [DATA_W-1:0] o_thr1
);

    logic [NUM_SOURCES-1:0] r_pend;
    logic [PRIO_W-1:0]      r_prio [NUM_SOURCES];
    logic [DATA_W-1:0]      r_ena  [CTX_N];
    logic [DATA_W-1:0]      r_thr  [CTX_N];

    logic [9:0]    slot;
    logic          slot_ok;
    logic          src_ok;
    logic [SW-1:0] reg_idx;
    logic [SW-1:0] prio_addr;
    logic          ena_hit;

    // Decode the priority slot and source range
    assign slot      = i_off[11:2];
    assign slot_ok   = (slot < 10'(NUM_SOURCES));
    assign src_ok    = (i_src != '0) && ({1'b0, i_src} < 6'(NUM_SOURCES));
    assign reg_idx   = i_off[SW+1:2];
    assign ena_hit   = (i_off >= OFF_ENA_BASE) && (i_off < OFF_ENA_END);

    // Share one priority read port between scan and register reads
    assign prio_addr = i_ctl.scan_sel ? i_scan_idx : reg_idx;
    assign o_prio    = r_prio[prio_addr];

    // Candidate bits for both contexts at the scan index
    assign o_cand[0] = r_pend[i_scan_idx] & r_ena[0][SRC_W'(i_scan_idx)];
    assign o_cand[1] = r_pend[i_scan_idx] & r_ena[1][SRC_W'(i_scan_idx)];
    assign o_thr0    = r_thr[0];
    assign o_thr1    = r_thr[1];

    // Register read mux; claim offsets are served by the sequencer
    always_comb begin
        o_rdata = '0;
        if (i_off < OFF_PEND_BASE) begin
            if (slot_ok) begin
                o_rdata = DATA_W'(o_prio);
            end
        end else if (i_off < OFF_ENA_BASE) begin
            o_rdata = DATA_W'(r_pend);
        end else if (ena_hit) begin
            // Context stride is 0x80 inside a 0x100 window
            o_rdata = r_ena[i_off[7]];
        end else if (i_off == OFF_THR0) begin
            o_rdata = r_thr[0];
        end else if (i_off == OFF_THR1) begin
            o_rdata = r_thr[1];
        end
    end

    // Update pending bits from level changes and claims
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            if (i_ctl.lvl && src_ok) begin
                r_pend[i_src[SW-1:0]] <= i_lvl;
            end
            if (i_ctl.clr && (i_clr_id != '0)) begin
                r_pend[i_clr_id] <= 1'b0;
            end
        end
    end

    // Write priority, enable and threshold registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_SOURCES; i++) begin
                r_prio[i] <= '0;
            end
            for (int c = 0; c < CTX_N; c++) begin
                r_ena[c] <= '0;
                r_thr[c] <= '0;
            end
        end else if (i_ctl.wr) begin
            if (i_off < OFF_PEND_BASE) begin
                if (slot_ok) begin
                    r_prio[reg_idx] <= i_wdata[PRIO_W-1:0];
                end
            end else if (ena_hit) begin
                r_ena[i_off[7]] <= i_wdata;
            end else if (i_off == OFF_THR0) begin
                r_thr[0] <= i_wdata;
            end else if (i_off == OFF_THR1) begin
                r_thr[1] <= i_wdata;
            end
        end
    end

endmodule

// ----- rtl/icc_scan.sv -----
module icc_scan
    import icc_pkg::*;
#(
    parameter int unsigned NUM_SOURCES = 32,
    parameter int unsigned SW          = 5
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_scan_ctl         i_ctl,
    input  logic [DATA_W-1:0] i_thr0,
    input  logic [DATA_W-1:0] i_thr1,
    input  logic [CTX_N-1:0]  i_cand,
    input  logic [PRIO_W-1:0] i_prio,
    output logic [SW-1:0]     o_idx,
    output logic              o_last,
    output logic [SW-1:0]     o_win0,
    output logic [SW-1:0]     o_win1
);

    logic [SW-1:0]     r_idx;
    logic [DATA_W-1:0] r_top0;
    logic [DATA_W-1:0] r_top1;
    logic [SW-1:0]     r_win0;
    logic [SW-1:0]     r_win1;
    logic [DATA_W-1:0] prio_ext;
    logic              take0;
    logic              take1;

    // Strictly greater keeps the lowest source number on a tie
    assign prio_ext = DATA_W'(i_prio);
    assign take0    = i_cand[0] && (prio_ext > r_top0);
    assign take1    = i_cand[1] && (prio_ext > r_top1);

    assign o_idx  = r_idx;
    assign o_last = (r_idx == SW'(NUM_SOURCES - 1));
    assign o_win0 = r_win0;
    assign o_win1 = r_win1;

    // Walk sources one per cycle, keeping the best per context
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx  <= '0;
            r_win0 <= '0;
            r_win1 <= '0;
        end else if (i_ctl.start) begin
            r_idx  <= SW'(1);
            r_win0 <= '0;
            r_win1 <= '0;
        end else if (i_ctl.step) begin
            r_idx <= r_idx + SW'(1);
            if (take0) begin
                r_win0 <= r_idx;
            end
            if (take1) begin
                r_win1 <= r_idx;
            end
        end
    end

    // Running best priority, seeded with the thresholds
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_top0 <= i_thr0;
            r_top1 <= i_thr1;
        end else if (i_ctl.step) begin
            if (take0) begin
                r_top0 <= prio_ext;
            end
            if (take1) begin
                r_top1 <= prio_ext;
            end
        end
    end

endmodule

// ----- rtl/interrupt_controller_claim.sv -----
// Channel | Direction | Valid       | Stall       | Payload
// input   | in        | i_in_valid  | o_in_stall  | i_in  (t_in)
// output  | out       | o_out_valid | i_out_stall | o_out (t_out)
//
// A claim read needs a second pass: the first scan picks and clears the winner, the
// second refreshes the context lines. The scan unit compares one source per cycle for
// both contexts. Synchronous active-low reset clears the state, valid flag, pending bits,
// priorities, enables and thresholds; the held transaction and result are not reset.
// The result sits in an output register; a stalled output holds the sequencer in S_DONE,
// and the next transaction waits, until the register frees up.
module interrupt_controller_claim
    import icc_pkg::*;
#(
    parameter int unsigned NUM_SOURCES = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out
);

    localparam int unsigned SW = $clog2(NUM_SOURCES);

    t_state            r_state;
    t_state            n_state;
    t_in               r_item;
    logic [DATA_W-1:0] r_rdata;
    logic [DATA_W-1:0] n_rdata;
    t_out              r_out;
    logic              r_out_valid;
    logic              n_out_valid;

    t_reg_ctl          reg_ctl;
    t_scan_ctl         scan_ctl;
    logic [DATA_W-1:0] reg_rdata;
    logic [PRIO_W-1:0] prio;
    logic [CTX_N-1:0]  cand;
    logic [DATA_W-1:0] thr0;
    logic [DATA_W-1:0] thr1;
    logic [SW-1:0]     scan_idx;
    logic              scan_last;
    logic [SW-1:0]     win0;
    logic [SW-1:0]     win1;
    logic [SW-1:0]     claim_id;
    logic              is_claim;
    logic              out_free;

    // Decode a claim read; context is picked by the 0x1000 offset bit
    assign is_claim = (r_item.cmd == CMD_READ) &&
                      ((r_item.reg_offset == OFF_CLAIM0) ||
                       (r_item.reg_offset == OFF_CLAIM1));
    assign claim_id = r_item.reg_offset[12] ? win1 : win0;
    assign out_free = !r_out_valid || !i_out_stall;

    icc_regs #(
        .NUM_SOURCES (NUM_SOURCES),
        .SW          (SW)
    ) u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (reg_ctl),
        .i_off      (r_item.reg_offset),
        .i_wdata    (r_item.write_data),
        .i_src      (r_item.source_number),
        .i_lvl      (r_item.source_level),
        .i_clr_id   (claim_id),
        .i_scan_idx (scan_idx),
        .o_rdata    (reg_rdata),
        .o_prio     (prio),
        .o_cand     (cand),
        .o_thr0     (thr0),
        .o_thr1     (thr1)
    );

    icc_scan #(
        .NUM_SOURCES (NUM_SOURCES),
        .SW          (SW)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (scan_ctl),
        .i_thr0  (thr0),
        .i_thr1  (thr1),
        .i_cand  (cand),
        .i_prio  (prio),
        .o_idx   (scan_idx),
        .o_last  (scan_last),
        .o_win0  (win0),
        .o_win1  (win1)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC:        n_state = S_ARM;
            S_ARM:         n_state = is_claim ? S_CLAIM_SCAN : S_LINE_SCAN;
            S_CLAIM_SCAN: begin
                if (scan_last) begin
                    n_state = S_CLAIM_CLEAR;
                end
            end
            S_CLAIM_CLEAR: n_state = S_LINE_SCAN;
            S_LINE_SCAN: begin
                if (scan_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:       n_state = S_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        o_in_stall     = 1'b1;
        reg_ctl        = '0;
        scan_ctl       = '0;
        n_rdata        = r_rdata;
        reg_ctl.scan_sel = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
            end
            S_EXEC: begin
                reg_ctl.scan_sel = 1'b0;
                reg_ctl.wr       = (r_item.cmd == CMD_WRITE);
                reg_ctl.lvl      = (r_item.cmd == CMD_LEVEL);
                n_rdata          = (r_item.cmd == CMD_READ) ? reg_rdata : '0;
            end
            S_ARM: begin
                scan_ctl.start = 1'b1;
            end
            S_CLAIM_SCAN: begin
                scan_ctl.step = 1'b1;
            end
            S_CLAIM_CLEAR: begin
                reg_ctl.clr    = 1'b1;
                scan_ctl.start = 1'b1;
                n_rdata        = DATA_W'(claim_id);
            end
            S_LINE_SCAN: begin
                scan_ctl.step = 1'b1;
            end
            S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    // Output valid: set on load, drop when taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        if ((r_state == S_DONE) && out_free) begin
            n_out_valid = 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Hold the transaction, read data and result
    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && i_in_valid) begin
            r_item <= i_in;
        end
        r_rdata <= n_rdata;
        if ((r_state == S_DONE) && out_free) begin
            r_out.read_data     <= r_rdata;
            r_out.context_lines <= {(win1 != '0), (win0 != '0)};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule
